// ===== rtl/core/lfpi_pkg.sv =====
// Shared widths, types and constants for the four-point Lagrange interpolator.
package lfpi_pkg;

  // Input field widths.
  localparam int H_W = 10;
  localparam int T_W = 12;

  // Number of samples and nodes.
  localparam int N_TAPS = 4;

  // Node distance t - i*h lies in -3069..4095.
  localparam int D_W = 13;
  // Product of two and of three node distances.
  localparam int PAIR_W = 2 * D_W;
  localparam int TRIP_W = 3 * D_W;
  // Weight with the factor of three applied, plus one bit of margin.
  localparam int WGT_W = TRIP_W + 1;
  // Weight is split into two halves for the sample multipliers.
  localparam int WLO_W = WGT_W / 2;
  localparam int WHI_W = WGT_W - WLO_W;
  // Growth of the sum of four weighted terms.
  localparam int WGT_GROW = 2;

  // Spacing powers and the divisor 6*h^3.
  localparam int HSQ_W = 2 * H_W;
  localparam int HCUBE_W = 3 * H_W;
  localparam int DEN_W = HCUBE_W + 3;

  // Register stages in the weight generator.
  localparam int WGT_LAT = 4;

  typedef logic signed [D_W-1:0] dist_t;
  typedef logic signed [WGT_W-1:0] wgt_t;

  // Control that travels alongside the magnitude into the divider.
  typedef struct packed {
    logic valid;
    logic neg;
    logic sat;
  } ctl_t;

endpackage

// ===== rtl/core/lagrange_four_point_interp.sv =====
// Throughput: one transaction per clock; the quotient is formed one bit per pipeline stage.
// busy is low whenever reset is released, so start is taken on every cycle.
// Results carry no backpressure: each sits on the out_ ports for one cycle with out_valid.
// Reset is synchronous and active low; it clears every valid bit and drops work in flight.
module lagrange_four_point_interp #(
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_0,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_1,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_2,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_3,
  input  logic [lfpi_pkg::H_W-1:0]       in_sample_spacing,
  input  logic [lfpi_pkg::T_W-1:0]       in_target_offset,
  output logic                           out_valid,
  output logic signed [SAMPLE_WIDTH-1:0] out_interpolated,
  output logic                           out_saturated
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int N_TAPS = lfpi_pkg::N_TAPS;
  localparam int WGT_LAT = lfpi_pkg::WGT_LAT;
  localparam int MAG_W = SW + lfpi_pkg::WGT_W + lfpi_pkg::WGT_GROW;

  logic                          accept;
  logic signed [SW-1:0]          in_smp [N_TAPS];
  logic signed [SW-1:0]          smp_r [WGT_LAT][N_TAPS];

  logic                          w_valid;
  lfpi_pkg::wgt_t                w_wgt [N_TAPS];
  logic [lfpi_pkg::DEN_W-1:0]    w_den;

  lfpi_pkg::ctl_t                a_ctl;
  logic [MAG_W-1:0]              a_mag;
  logic [lfpi_pkg::DEN_W-1:0]    a_den;

  // A transaction is taken on every cycle outside reset.
  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  assign in_smp[0] = in_sample_0;
  assign in_smp[1] = in_sample_1;
  assign in_smp[2] = in_sample_2;
  assign in_smp[3] = in_sample_3;

  // Samples wait here while the weights are formed.
  always_ff @(posedge clk) begin
    smp_r[0] <= in_smp;
    for (int j = 1; j < WGT_LAT; j++) begin
      smp_r[j] <= smp_r[j-1];
    end
  end

  lfpi_weights u_weights (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .spacing   (in_sample_spacing),
    .offset    (in_target_offset),
    .out_valid (w_valid),
    .wgt       (w_wgt),
    .den       (w_den)
  );

  lfpi_accum #(
    .SAMPLE_WIDTH (SW)
  ) u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (w_valid),
    .sample   (smp_r[WGT_LAT-1]),
    .wgt      (w_wgt),
    .den      (w_den),
    .ctl      (a_ctl),
    .mag      (a_mag),
    .den_o    (a_den)
  );

  lfpi_div #(
    .SAMPLE_WIDTH (SW)
  ) u_div (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl_in           (a_ctl),
    .mag              (a_mag),
    .den              (a_den),
    .out_valid        (out_valid),
    .out_interpolated (out_interpolated),
    .out_saturated    (out_saturated)
  );

endmodule

// ===== rtl/core/lfpi_weights.sv =====
// Weight generator: node distances, their products and the divisor 6*h^3.
module lfpi_weights (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [lfpi_pkg::H_W-1:0]       spacing,
  input  logic [lfpi_pkg::T_W-1:0]       offset,
  output logic                           out_valid,
  output lfpi_pkg::wgt_t                 wgt [lfpi_pkg::N_TAPS],
  output logic [lfpi_pkg::DEN_W-1:0]     den
);

  localparam int H_W = lfpi_pkg::H_W;
  localparam int T_W = lfpi_pkg::T_W;
  localparam int D_W = lfpi_pkg::D_W;
  localparam int PAIR_W = lfpi_pkg::PAIR_W;
  localparam int TRIP_W = lfpi_pkg::TRIP_W;
  localparam int WGT_W = lfpi_pkg::WGT_W;
  localparam int HSQ_W = lfpi_pkg::HSQ_W;
  localparam int HCUBE_W = lfpi_pkg::HCUBE_W;
  localparam int DEN_W = lfpi_pkg::DEN_W;
  localparam int N_TAPS = lfpi_pkg::N_TAPS;

  // Stage valid bits.
  logic v1_r, v2_r, v3_r, v4_r;

  // Stage 1 signals.
  logic [H_W-1:0]       h_eff;
  logic [T_W-1:0]       t_eff;
  logic [T_W-1:0]       h_x1, h_x2, h_x3;
  lfpi_pkg::dist_t      d1_nxt [N_TAPS];
  lfpi_pkg::dist_t      d1_r [N_TAPS];
  logic [H_W-1:0]       hs1_r;

  // Stage 2 signals.
  logic signed [PAIR_W-1:0] pa_nxt, pb_nxt;
  logic signed [PAIR_W-1:0] pa_r, pb_r;
  lfpi_pkg::dist_t          dk2_r [N_TAPS];
  logic [HSQ_W-1:0]         hsq_nxt;
  logic [HSQ_W-1:0]         hsq2_r;
  logic [H_W-1:0]           hs2_r;

  // Stage 3 signals.
  logic signed [TRIP_W-1:0] p_nxt [N_TAPS];
  logic signed [TRIP_W-1:0] p_r [N_TAPS];
  logic [HCUBE_W-1:0]       hc_nxt;
  logic [HCUBE_W-1:0]       hc3_r;

  // Stage 4 signals.
  lfpi_pkg::wgt_t           px [N_TAPS];
  lfpi_pkg::wgt_t           wgt_nxt [N_TAPS];
  lfpi_pkg::wgt_t           wgt_r [N_TAPS];
  logic [DEN_W-1:0]         den_nxt;
  logic [DEN_W-1:0]         den_r;

  // Zero spacing is evaluated as spacing one at offset zero, which lands exactly
  // on node zero and so returns the first sample unchanged.
  always_comb begin
    h_eff = (spacing == '0) ? H_W'(1) : spacing;
    t_eff = (spacing == '0) ? '0 : offset;
    h_x1 = T_W'(h_eff);
    h_x2 = T_W'({h_eff, 1'b0});
    h_x3 = h_x1 + h_x2;
    d1_nxt[0] = $signed({1'b0, t_eff});
    d1_nxt[1] = $signed({1'b0, t_eff}) - $signed({1'b0, h_x1});
    d1_nxt[2] = $signed({1'b0, t_eff}) - $signed({1'b0, h_x2});
    d1_nxt[3] = $signed({1'b0, t_eff}) - $signed({1'b0, h_x3});
  end

  // Pair products and h squared.
  always_comb begin
    pa_nxt = d1_r[2] * d1_r[3];
    pb_nxt = d1_r[0] * d1_r[1];
    hsq_nxt = hs1_r * hs1_r;
  end

  // Triple products, each leaving out its own node, and h cubed.
  always_comb begin
    p_nxt[0] = dk2_r[1] * pa_r;
    p_nxt[1] = dk2_r[0] * pa_r;
    p_nxt[2] = dk2_r[3] * pb_r;
    p_nxt[3] = dk2_r[2] * pb_r;
    hc_nxt = hsq2_r * hs2_r;
  end

  // Apply the signs and the factors of three; the divisor is 4*h^3 + 2*h^3.
  always_comb begin
    for (int i = 0; i < N_TAPS; i++) begin
      px[i] = $signed({{(WGT_W - TRIP_W){p_r[i][TRIP_W-1]}}, p_r[i]});
    end
    wgt_nxt[0] = -px[0];
    wgt_nxt[1] = (px[1] <<< 1) + px[1];
    wgt_nxt[2] = -((px[2] <<< 1) + px[2]);
    wgt_nxt[3] = px[3];
    den_nxt = DEN_W'({hc3_r, 2'b00}) + DEN_W'({hc3_r, 1'b0});
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Data registers.
  always_ff @(posedge clk) begin
    d1_r   <= d1_nxt;
    hs1_r  <= h_eff;
    pa_r   <= pa_nxt;
    pb_r   <= pb_nxt;
    dk2_r  <= d1_r;
    hsq2_r <= hsq_nxt;
    hs2_r  <= hs1_r;
    p_r    <= p_nxt;
    hc3_r  <= hc_nxt;
    wgt_r  <= wgt_nxt;
    den_r  <= den_nxt;
  end

  assign out_valid = v4_r;
  assign wgt = wgt_r;
  assign den = den_r;

endmodule

// ===== rtl/core/lfpi_accum.sv =====
// Weighted sum of the four samples, its magnitude and the overflow test.
module lfpi_accum #(
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            in_valid,
  input  logic signed [SAMPLE_WIDTH-1:0]                  sample [lfpi_pkg::N_TAPS],
  input  lfpi_pkg::wgt_t                                  wgt [lfpi_pkg::N_TAPS],
  input  logic [lfpi_pkg::DEN_W-1:0]                      den,
  output lfpi_pkg::ctl_t                                  ctl,
  output logic [SAMPLE_WIDTH+lfpi_pkg::WGT_W+lfpi_pkg::WGT_GROW-1:0] mag,
  output logic [lfpi_pkg::DEN_W-1:0]                      den_o
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int N_TAPS = lfpi_pkg::N_TAPS;
  localparam int WGT_W = lfpi_pkg::WGT_W;
  localparam int WLO_W = lfpi_pkg::WLO_W;
  localparam int WHI_W = lfpi_pkg::WHI_W;
  localparam int DEN_W = lfpi_pkg::DEN_W;
  localparam int PH_W = SW + WHI_W;
  localparam int PL_W = SW + WLO_W + 1;
  localparam int TERM_W = SW + WGT_W;
  localparam int PSUM_W = TERM_W + 1;
  localparam int SUM_W = TERM_W + lfpi_pkg::WGT_GROW;
  localparam int CMP_W = SUM_W + 1;

  // Stage valid bits, stages E through J.
  logic ve_r, vf_r, vg_r, vh_r, vi_r;
  lfpi_pkg::ctl_t ctl_r;

  // Divisor delay line alongside the data.
  logic [DEN_W-1:0] den_e_r, den_f_r, den_g_r, den_h_r, den_i_r, den_j_r;

  // Stage E: partial products.
  logic signed [PH_W-1:0] ph_nxt [N_TAPS];
  logic signed [PH_W-1:0] ph_r [N_TAPS];
  logic signed [PL_W-1:0] pl_nxt [N_TAPS];
  logic signed [PL_W-1:0] pl_r [N_TAPS];

  // Stage F: full terms.
  logic signed [TERM_W-1:0] term_nxt [N_TAPS];
  logic signed [TERM_W-1:0] term_r [N_TAPS];

  // Stage G and H: adder tree.
  logic signed [PSUM_W-1:0] s01_nxt, s23_nxt, s01_r, s23_r;
  logic signed [SUM_W-1:0]  sum_nxt, sum_r;

  // Stage I: sign and magnitude.
  logic             neg_nxt, neg_i_r;
  logic [SUM_W-1:0] mag_nxt, mag_i_r, mag_j_r;

  // Stage J: overflow test.
  logic [CMP_W-1:0] den_ext, den_shl, lim_rhs, mag_x2;
  logic             sat_nxt;

  // Each weight is split into a signed high half and an unsigned low half.
  always_comb begin
    for (int i = 0; i < N_TAPS; i++) begin
      ph_nxt[i] = sample[i] * $signed(wgt[i][WGT_W-1:WLO_W]);
      pl_nxt[i] = sample[i] * $signed({1'b0, wgt[i][WLO_W-1:0]});
    end
  end

  // Recombine the two halves of each product.
  always_comb begin
    for (int i = 0; i < N_TAPS; i++) begin
      term_nxt[i] = $signed({ph_r[i], {WLO_W{1'b0}}})
                  + $signed({{(TERM_W - PL_W){pl_r[i][PL_W-1]}}, pl_r[i]});
    end
  end

  // Two-level adder tree.
  always_comb begin
    s01_nxt = $signed({term_r[0][TERM_W-1], term_r[0]})
            + $signed({term_r[1][TERM_W-1], term_r[1]});
    s23_nxt = $signed({term_r[2][TERM_W-1], term_r[2]})
            + $signed({term_r[3][TERM_W-1], term_r[3]});
    sum_nxt = $signed({s01_r[PSUM_W-1], s01_r}) + $signed({s23_r[PSUM_W-1], s23_r});
  end

  // Split the sum into sign and magnitude.
  always_comb begin
    neg_nxt = sum_r[SUM_W-1];
    mag_nxt = neg_nxt ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  end

  // The rounded quotient overflows when 2*mag >= (2*limit + 1) * den, where
  // 2*limit + 1 is 2^SW - 1 for a positive result and 2^SW + 1 for a negative one.
  always_comb begin
    den_ext = CMP_W'(den_i_r);
    den_shl = den_ext << SW;
    lim_rhs = neg_i_r ? (den_shl + den_ext) : (den_shl - den_ext);
    mag_x2  = {mag_i_r, 1'b0};
    sat_nxt = (mag_x2 >= lim_rhs);
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r  <= 1'b0;
      vf_r  <= 1'b0;
      vg_r  <= 1'b0;
      vh_r  <= 1'b0;
      vi_r  <= 1'b0;
      ctl_r <= '0;
    end else begin
      ve_r      <= in_valid;
      vf_r      <= ve_r;
      vg_r      <= vf_r;
      vh_r      <= vg_r;
      vi_r      <= vh_r;
      ctl_r.valid <= vi_r;
      ctl_r.neg   <= neg_i_r;
      ctl_r.sat   <= sat_nxt;
    end
  end

  // Data registers.
  always_ff @(posedge clk) begin
    ph_r    <= ph_nxt;
    pl_r    <= pl_nxt;
    term_r  <= term_nxt;
    s01_r   <= s01_nxt;
    s23_r   <= s23_nxt;
    sum_r   <= sum_nxt;
    neg_i_r <= neg_nxt;
    mag_i_r <= mag_nxt;
    mag_j_r <= mag_i_r;
    den_e_r <= den;
    den_f_r <= den_e_r;
    den_g_r <= den_f_r;
    den_h_r <= den_g_r;
    den_i_r <= den_h_r;
    den_j_r <= den_i_r;
  end

  assign ctl   = ctl_r;
  assign mag   = mag_j_r;
  assign den_o = den_j_r;

endmodule

// ===== rtl/core/lfpi_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with rounding and clipping.
module lfpi_div #(
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  lfpi_pkg::ctl_t                                  ctl_in,
  input  logic [SAMPLE_WIDTH+lfpi_pkg::WGT_W+lfpi_pkg::WGT_GROW-1:0] mag,
  input  logic [lfpi_pkg::DEN_W-1:0]                      den,
  output logic                                            out_valid,
  output logic signed [SAMPLE_WIDTH-1:0]                  out_interpolated,
  output logic                                            out_saturated
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int DEN_W = lfpi_pkg::DEN_W;
  localparam logic [SW-1:0] POS_LIM = {1'b0, {(SW - 1){1'b1}}};
  localparam logic [SW-1:0] NEG_LIM = {1'b1, {(SW - 1){1'b0}}};

  // Per-stage registers of the division chain.
  lfpi_pkg::ctl_t   ctl_r [SW];
  logic [DEN_W-1:0] den_r [SW];
  logic [DEN_W-1:0] rem_r [SW];
  logic [SW-1:0]    num_r [SW];
  logic [SW-1:0]    quo_r [SW];

  // Rounding and output stage.
  logic             rnd_up;
  logic [SW-1:0]    quo_rnd;
  logic [SW-1:0]    res_nxt;
  logic             out_valid_r;
  logic [SW-1:0]    out_interp_r;
  logic             out_sat_r;

  // Without overflow the quotient fits in SW bits, so the bits of the magnitude
  // above SW start as a partial remainder below the divisor.
  for (genvar k = 0; k < SW; k++) begin : g_stage
    lfpi_pkg::ctl_t   ctl_src;
    logic [DEN_W-1:0] den_src;
    logic [DEN_W-1:0] rem_src;
    logic [SW-1:0]    num_src;
    logic [SW-1:0]    quo_src;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             take;

    if (k == 0) begin : g_first
      assign ctl_src = ctl_in;
      assign den_src = den;
      assign rem_src = mag[SW+DEN_W-1:SW];
      assign num_src = mag[SW-1:0];
      assign quo_src = '0;
    end else begin : g_next
      assign ctl_src = ctl_r[k-1];
      assign den_src = den_r[k-1];
      assign rem_src = rem_r[k-1];
      assign num_src = num_r[k-1];
      assign quo_src = quo_r[k-1];
    end

    // Shift in the next numerator bit and subtract the divisor where it fits.
    always_comb begin
      trial = {rem_src, num_src[SW-1]};
      diff  = trial - {1'b0, den_src};
      take  = (trial >= {1'b0, den_src});
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k] <= '0;
      end else begin
        ctl_r[k] <= ctl_src;
      end
    end

    always_ff @(posedge clk) begin
      den_r[k] <= den_src;
      rem_r[k] <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      num_r[k] <= {num_src[SW-2:0], 1'b0};
      quo_r[k] <= {quo_src[SW-2:0], take};
    end
  end

  // Round half away from zero on the magnitude, then restore the sign or clip.
  always_comb begin
    rnd_up  = ({rem_r[SW-1], 1'b0} >= {1'b0, den_r[SW-1]});
    quo_rnd = quo_r[SW-1] + SW'(rnd_up);
    if (ctl_r[SW-1].sat) begin
      res_nxt = ctl_r[SW-1].neg ? NEG_LIM : POS_LIM;
    end else begin
      res_nxt = ctl_r[SW-1].neg ? (-quo_rnd) : quo_rnd;
    end
  end

  // Output register: the result strobe lasts one cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl_r[SW-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    out_interp_r <= res_nxt;
    out_sat_r    <= ctl_r[SW-1].sat;
  end

  assign out_valid        = out_valid_r;
  assign out_interpolated = $signed(out_interp_r);
  assign out_saturated    = out_sat_r;

endmodule

// ===== rtl/core/lfpi_checker.sv =====
// Port-level checks for the interpolator, bound to the top level.
module lfpi_checker #(
  parameter int SAMPLE_WIDTH = 32
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic signed [SAMPLE_WIDTH-1:0] in_sample_0,
  input logic signed [SAMPLE_WIDTH-1:0] in_sample_1,
  input logic signed [SAMPLE_WIDTH-1:0] in_sample_2,
  input logic signed [SAMPLE_WIDTH-1:0] in_sample_3,
  input logic [lfpi_pkg::H_W-1:0]       in_sample_spacing,
  input logic [lfpi_pkg::T_W-1:0]       in_target_offset,
  input logic                           out_valid,
  input logic signed [SAMPLE_WIDTH-1:0] out_interpolated,
  input logic                           out_saturated
);

  localparam int SW = SAMPLE_WIDTH;
  // Edges from the accepting edge to the edge that takes the result.
  localparam int LAT = SW + 11;
  localparam int CNT_W = $clog2(LAT + 1);
  localparam logic signed [SW-1:0] MAX_VAL = {1'b0, {(SW - 1){1'b1}}};
  localparam logic signed [SW-1:0] MIN_VAL = {1'b1, {(SW - 1){1'b0}}};

  logic [CNT_W-1:0] since_rst_r;
  logic [CNT_W-1:0] since_rst_nxt;
  logic             settled;

  // Count clean cycles after reset so that history checks look only at live transactions.
  assign since_rst_nxt = (since_rst_r == CNT_W'(LAT)) ? since_rst_r : since_rst_r + CNT_W'(1);
  assign settled = (since_rst_r == CNT_W'(LAT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      since_rst_r <= '0;
    end else begin
      since_rst_r <= since_rst_nxt;
    end
  end

  // Every accepted transaction yields exactly one result after the fixed latency.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    settled |-> (out_valid == $past(start && !busy, LAT)))
    else $error("result strobe does not match an accepted transaction");

  // A clipped result sits at one of the two range limits.
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_interpolated == MAX_VAL || out_interpolated == MIN_VAL))
    else $error("saturated result is not at a range limit");

  // Zero spacing passes the first sample through unclipped.
  a_zero_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    (settled && out_valid && $past(in_sample_spacing, LAT) == '0) |->
      (out_interpolated == $past(in_sample_0, LAT) && !out_saturated))
    else $error("zero spacing did not return the first sample");

  // An offset on node zero returns the first sample exactly.
  a_node_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (settled && out_valid && $past(in_target_offset, LAT) == '0) |->
      (out_interpolated == $past(in_sample_0, LAT) && !out_saturated))
    else $error("offset on the first node did not return the first sample");

endmodule

bind lagrange_four_point_interp lfpi_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_lfpi_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .in_sample_0       (in_sample_0),
  .in_sample_1       (in_sample_1),
  .in_sample_2       (in_sample_2),
  .in_sample_3       (in_sample_3),
  .in_sample_spacing (in_sample_spacing),
  .in_target_offset  (in_target_offset),
  .out_valid         (out_valid),
  .out_interpolated  (out_interpolated),
  .out_saturated     (out_saturated)
);
